/* sv/assert_macros.svh */
// Assertion macros for the checker file of the date counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cdc_pkg.sv */
// Shared types and constants of the calendar date counter.
`default_nettype none

package cdc_pkg;

  localparam logic [13:0] YEAR_MAX        = 14'd9999;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  // Multiplicative inverse of 25 modulo 2^14, and the largest product that
  // marks a multiple of 25 (floor((2^14 - 1) / 25)).
  localparam logic [13:0] INV25           = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT     = 14'd655;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_NEXT = 2'd1,
    CMD_PREV = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
  } req_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [3:0]  year_thousands;
    logic [3:0]  year_hundreds;
    logic [3:0]  year_tens;
    logic [3:0]  year_units;
    logic        month_tens;
    logic [3:0]  month_units;
    logic [1:0]  day_tens;
    logic [3:0]  day_units;
  } rsp_t;

endpackage

`default_nettype wire

/* sv/calendar_date_up_down_counter.sv */
// Gregorian date counter: load, next day, previous day, read.
// A request passes the request register, the date register and the digit stages.
// Throughput: one request per cycle while no stall holds the pipeline; the date register updates in one pass.
// The date register sits between the request register and a 3-stage digit pipeline.
// Reset (synchronous) sets the date to 0000-01-01 and empties all stages.
`default_nettype none

module calendar_date_up_down_counter (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cdc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cdc_pkg::rsp_t rsp
);
  import cdc_pkg::*;

  req_t  q;
  logic  q_v;
  logic  q_rdy;
  logic  a_v;
  logic  a_rdy;
  logic  d_stall;
  logic  step;
  date_t date;

  // Ready chain and the step into the date register
  always_comb begin
    a_rdy     = !a_v || !d_stall;
    q_rdy     = !q_v || a_rdy;
    step      = q_v && a_rdy;
    req_stall = !q_rdy;
  end

  // Request register and date-stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
      a_v <= 1'b0;
    end else begin
      if (q_rdy) begin
        q_v <= req_valid;
      end
      if (a_rdy) begin
        a_v <= q_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rdy) begin
      q <= req;
    end
  end

  cdc_update u_update (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (q),
    .date (date)
  );

  cdc_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .date_valid (a_v),
    .date       (date),
    .date_stall (d_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

/* sv/cdc_update.sv */
// Date state register and the one-day step, load and read logic.
`default_nettype none

module cdc_update (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  cdc_pkg::req_t req,
  output cdc_pkg::date_t date
);
  import cdc_pkg::*;

  date_t       date_next;
  logic [27:0] inv_full;
  logic [13:0] inv_prod;
  logic        div25;
  logic        leap;
  logic [3:0]  month_prev;
  logic [4:0]  len_cur;
  logic [4:0]  len_prev;
  logic [5:0]  day_inc;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    case (m) inside
      4'd2:                    len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Leap test: divisible by 4, and not by 25 unless also by 16
  always_comb begin
    inv_full = date.year * INV25;
    inv_prod = inv_full[13:0];
    div25    = (inv_prod <= DIV25_LIMIT);
    leap     = (date.year[1:0] == 2'd0) && (!div25 || (date.year[3:0] == 4'd0));
  end

  // Month lengths of the current and the previous month; only February
  // depends on the year, and it never follows a year change going back
  always_comb begin
    month_prev = (date.month <= 4'd1) ? MONTHS_PER_YEAR : date.month - 4'd1;
    len_cur    = month_len(date.month, leap);
    len_prev   = month_len(month_prev, leap);
    day_inc    = {1'b0, date.day} + 6'd1;
  end

  // Apply the command
  always_comb begin
    date_next = date;
    unique case (req.cmd)
      CMD_LOAD: begin
        date_next.year  = (req.load_year > YEAR_MAX) ? YEAR_MAX : req.load_year;
        if (req.load_month == 4'd0) begin
          date_next.month = 4'd1;
        end else if (req.load_month > MONTHS_PER_YEAR) begin
          date_next.month = MONTHS_PER_YEAR;
        end else begin
          date_next.month = req.load_month;
        end
        date_next.day = (req.load_day == 5'd0) ? 5'd1 : req.load_day;
      end
      CMD_NEXT: begin
        if (day_inc > {1'b0, len_cur}) begin
          date_next.day = 5'd1;
          if (date.month >= MONTHS_PER_YEAR) begin
            date_next.month = 4'd1;
            date_next.year  = (date.year >= YEAR_MAX) ? 14'd0 : date.year + 14'd1;
          end else begin
            date_next.month = date.month + 4'd1;
          end
        end else begin
          date_next.day = day_inc[4:0];
        end
      end
      CMD_PREV: begin
        if (date.day > 5'd1) begin
          date_next.day = date.day - 5'd1;
        end else begin
          date_next.month = month_prev;
          date_next.day   = len_prev;
          if (date.month <= 4'd1) begin
            date_next.year = (date.year == 14'd0) ? YEAR_MAX : date.year - 14'd1;
          end
        end
      end
      CMD_READ: begin
        date_next = date;
      end
      default: begin
        date_next = date;
      end
    endcase
  end

  // Hold the date; reset to 0000-01-01
  always_ff @(posedge clk) begin
    if (rst) begin
      date <= '{year: 14'd0, month: 4'd1, day: 5'd1};
    end else if (step) begin
      date <= date_next;
    end
  end

endmodule

`default_nettype wire

/* sv/cdc_digits.sv */
// Three-stage binary to decimal digit pipeline with the result register.
`default_nettype none

module cdc_digits (
  input  logic           clk,
  input  logic           rst,
  input  logic           date_valid,
  input  cdc_pkg::date_t date,
  output logic           date_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cdc_pkg::rsp_t  rsp
);
  import cdc_pkg::*;

  rsp_t        b_rsp;
  logic [9:0]  b_rem;
  logic        b_v;
  rsp_t        c_rsp;
  logic [6:0]  c_rem;
  logic        c_v;

  logic        o_rdy;
  logic        c_rdy;
  logic        b_rdy;

  rsp_t        b_rsp_next;
  logic [13:0] th_diff;
  logic [4:0]  day_diff;
  logic [9:0]  h_diff;
  logic [3:0]  hund;
  rsp_t        c_rsp_next;
  logic [6:0]  t_diff;
  logic [3:0]  tens;
  rsp_t        rsp_next;

  // Ready chain back from the result register
  always_comb begin
    o_rdy      = !rsp_valid || !rsp_stall;
    c_rdy      = !c_v || o_rdy;
    b_rdy      = !b_v || c_rdy;
    date_stall = !b_rdy;
  end

  // Thousands digit of the year, and month and day digits
  always_comb begin
    b_rsp_next           = '0;
    b_rsp_next.cur_year  = date.year;
    b_rsp_next.cur_month = date.month;
    b_rsp_next.cur_day   = date.day;
    for (int k = 1; k <= 9; k++) begin
      if (date.year >= 14'(k * 1000)) begin
        b_rsp_next.year_thousands = 4'(k);
      end
    end
    th_diff = date.year - 14'(b_rsp_next.year_thousands) * 14'd1000;

    b_rsp_next.month_tens  = (date.month >= 4'd10);
    b_rsp_next.month_units = b_rsp_next.month_tens ? date.month - 4'd10 : date.month;

    if (date.day >= 5'd30) begin
      b_rsp_next.day_tens = 2'd3;
    end else if (date.day >= 5'd20) begin
      b_rsp_next.day_tens = 2'd2;
    end else if (date.day >= 5'd10) begin
      b_rsp_next.day_tens = 2'd1;
    end else begin
      b_rsp_next.day_tens = 2'd0;
    end
    day_diff              = date.day - 5'(b_rsp_next.day_tens) * 5'd10;
    b_rsp_next.day_units  = day_diff[3:0];
  end

  // Hundreds digit of the remainder below 1000
  always_comb begin
    hund = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (b_rem >= 10'(k * 100)) begin
        hund = 4'(k);
      end
    end
    h_diff                   = b_rem - 10'(hund) * 10'd100;
    c_rsp_next               = b_rsp;
    c_rsp_next.year_hundreds = hund;
  end

  // Tens and units of the remainder below 100
  always_comb begin
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (c_rem >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    t_diff              = c_rem - 7'(tens) * 7'd10;
    rsp_next            = c_rsp;
    rsp_next.year_tens  = tens;
    rsp_next.year_units = t_diff[3:0];
  end

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (b_rdy) begin
        b_v <= date_valid;
      end
      if (c_rdy) begin
        c_v <= b_v;
      end
      if (o_rdy) begin
        rsp_valid <= c_v;
      end
    end
  end

  // Advance the stage payloads
  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_rsp <= b_rsp_next;
      b_rem <= th_diff[9:0];
    end
    if (c_rdy) begin
      c_rsp <= c_rsp_next;
      c_rem <= h_diff[6:0];
    end
    if (o_rdy) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* sv/cdc_checker.sv */
// Port-level checks of the date counter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module cdc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input cdc_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input cdc_pkg::rsp_t rsp
);
  import cdc_pkg::*;

  logic req_wait;
  logic rsp_wait;
  logic digits_ok;
  logic range_ok;

  assign req_wait = req_valid && req_stall;
  assign rsp_wait = rsp_valid && rsp_stall;

  // Decimal digits rebuilt into the binary fields
  assign digits_ok =
    (32'(rsp.year_thousands) * 32'd1000 + 32'(rsp.year_hundreds) * 32'd100 +
     32'(rsp.year_tens) * 32'd10 + 32'(rsp.year_units) == 32'(rsp.cur_year)) &&
    (32'(rsp.month_tens) * 32'd10 + 32'(rsp.month_units) == 32'(rsp.cur_month)) &&
    (32'(rsp.day_tens) * 32'd10 + 32'(rsp.day_units) == 32'(rsp.cur_day));

  assign range_ok = (rsp.cur_year <= YEAR_MAX) && (rsp.cur_month != 4'd0) &&
                    (rsp.cur_month <= MONTHS_PER_YEAR) && (rsp.cur_day != 5'd0);

  // Reset empties the result register
  `CDC_ASSERT_ALWAYS(a_reset_empty, (rst |=> !rsp_valid), "result valid after reset")

  // A stalled result holds
  `CDC_ASSERT(a_stall_hold, (rsp_wait |=> rsp_valid && $stable(rsp)), "stalled result changed")

  // Decimal digits agree with the binary date
  `CDC_ASSERT(a_digits, (rsp_valid |-> digits_ok), "digits mismatch")

  // The reported date stays in range
  `CDC_ASSERT(a_range, (rsp_valid |-> range_ok), "date out of range")

  // A stalled request stays offered unchanged
  `CDC_ASSERT(a_req_hold, (req_wait |=> req_valid && $stable(req)), "stalled request changed")

endmodule

bind calendar_date_up_down_counter cdc_checker u_cdc_checker (.*);

`default_nettype wire

/* tb/sv/calendar_date_up_down_counter_test.sv */
// Self-checking testbench of the calendar date up/down counter.
`default_nettype none

module calendar_date_up_down_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdc_pkg::*;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_stall;
  rsp_t  rsp;

  // Date the block should hold after every accepted request
  date_t tracked_date;
  // Results owed by the block, oldest first
  rsp_t  pending_dates[$];

  int    mismatch_count = 0;
  int    checked_count  = 0;
  int    cmd_count[4];
  bit    send_idle_on   = 1'b1;
  bit    stall_idle_on  = 1'b1;
  int    hold_left      = 0;

  calendar_date_up_down_counter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up after a fixed time far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Timeout with %0d results still owed", pending_dates.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int y, input int m);
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // Apply one request to the tracked date and form the result it owes
  function automatic rsp_t apply_date_command(input req_t r);
    rsp_t res;
    int   d;
    int   y;
    int   m;
    case (r.cmd)
      CMD_LOAD: begin
        tracked_date.year  = (r.load_year > YEAR_MAX) ? YEAR_MAX : r.load_year;
        tracked_date.month = (r.load_month == 4'd0) ? 4'd1 :
                             (r.load_month > MONTHS_PER_YEAR) ? MONTHS_PER_YEAR : r.load_month;
        tracked_date.day   = (r.load_day == 5'd0) ? 5'd1 : r.load_day;
      end
      CMD_NEXT: begin
        d = int'(tracked_date.day) + 1;
        if (d > days_in_month(int'(tracked_date.year), int'(tracked_date.month))) begin
          d = 1;
          if (tracked_date.month >= MONTHS_PER_YEAR) begin
            tracked_date.month = 4'd1;
            tracked_date.year  = (tracked_date.year >= YEAR_MAX) ? 14'd0 :
                                 tracked_date.year + 14'd1;
          end else begin
            tracked_date.month = tracked_date.month + 4'd1;
          end
        end
        tracked_date.day = 5'(d);
      end
      CMD_PREV: begin
        if (tracked_date.day > 5'd1) begin
          tracked_date.day = tracked_date.day - 5'd1;
        end else begin
          if (tracked_date.month <= 4'd1) begin
            tracked_date.month = MONTHS_PER_YEAR;
            tracked_date.year  = (tracked_date.year == 14'd0) ? YEAR_MAX :
                                 tracked_date.year - 14'd1;
          end else begin
            tracked_date.month = tracked_date.month - 4'd1;
          end
          tracked_date.day = 5'(days_in_month(int'(tracked_date.year),
                                              int'(tracked_date.month)));
        end
      end
      default: ;
    endcase
    y = int'(tracked_date.year);
    m = int'(tracked_date.month);
    d = int'(tracked_date.day);
    res.cur_year       = 14'(y);
    res.cur_month      = 4'(m);
    res.cur_day        = 5'(d);
    res.year_thousands = 4'(y / 1000);
    res.year_hundreds  = 4'((y % 1000) / 100);
    res.year_tens      = 4'((y % 100) / 10);
    res.year_units     = 4'(y % 10);
    res.month_tens     = 1'(m / 10);
    res.month_units    = 4'(m % 10);
    res.day_tens       = 2'(d / 10);
    res.day_units      = 4'(d % 10);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d (result %0d)", name, got, want,
                                checked_count));
  endtask

  // Offer one request, with an optional idle burst first, and hold it until taken
  task automatic send_request(input cmd_t c, input int y, input int m, input int d);
    req_t r;
    r.cmd        = c;
    r.load_year  = 14'(y);
    r.load_month = 4'(m);
    r.load_day   = 5'(d);
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_dates.push_back(apply_date_command(r));
    cmd_count[c]++;
  endtask

  // Step or read with random content in the unused load fields
  task automatic send_step(input cmd_t c);
    send_request(c, $urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
  endtask

  // Drive the response stall: a long hold when one is asked for, else random bursts
  initial begin : rsp_stall_driver
    int stall_left;
    stall_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (stall_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        want = pending_dates.pop_front();
        check_field("cur_year",       16'(rsp.cur_year),       16'(want.cur_year));
        check_field("cur_month",      16'(rsp.cur_month),      16'(want.cur_month));
        check_field("cur_day",        16'(rsp.cur_day),        16'(want.cur_day));
        check_field("year_thousands", 16'(rsp.year_thousands), 16'(want.year_thousands));
        check_field("year_hundreds",  16'(rsp.year_hundreds),  16'(want.year_hundreds));
        check_field("year_tens",      16'(rsp.year_tens),      16'(want.year_tens));
        check_field("year_units",     16'(rsp.year_units),     16'(want.year_units));
        check_field("month_tens",     16'(rsp.month_tens),     16'(want.month_tens));
        check_field("month_units",    16'(rsp.month_units),    16'(want.month_units));
        check_field("day_tens",       16'(rsp.day_tens),       16'(want.day_tens));
        check_field("day_units",      16'(rsp.day_units),      16'(want.day_units));
        checked_count++;
      end
    end
  end

  // Read the reset date, then wrap the year both ways
  task automatic test_reset_state();
    send_step(CMD_READ);
    send_step(CMD_PREV);
    send_step(CMD_NEXT);
  endtask

  // Clamp out-of-range load fields, keep an overlong day as given
  task automatic test_load_limits();
    send_request(CMD_LOAD, 16383, 15, 31);
    send_request(CMD_LOAD, 0, 0, 0);
    send_request(CMD_LOAD, 2021, 2, 31);
    send_step(CMD_NEXT);
    send_request(CMD_LOAD, 2021, 2, 31);
    send_step(CMD_PREV);
  endtask

  // Cover the leap rule: by 400, by 100, by 4, and year zero
  task automatic test_leap_rule();
    send_request(CMD_LOAD, 2000, 2, 28);
    send_step(CMD_NEXT);
    send_step(CMD_NEXT);
    send_request(CMD_LOAD, 1900, 2, 28);
    send_step(CMD_NEXT);
    send_request(CMD_LOAD, 2024, 3, 1);
    send_step(CMD_PREV);
    send_request(CMD_LOAD, 0, 3, 1);
    send_step(CMD_PREV);
    send_step(CMD_NEXT);
  endtask

  // Roll over month and year ends in both directions
  task automatic test_month_ends();
    send_request(CMD_LOAD, 2021, 4, 30);
    send_step(CMD_NEXT);
    send_request(CMD_LOAD, 2021, 12, 31);
    send_step(CMD_NEXT);
    send_request(CMD_LOAD, 2021, 1, 1);
    send_step(CMD_PREV);
  endtask

  // Load a date, mostly near a month edge, then walk from it
  task automatic test_random_walks(input int total);
    int   sent;
    int   run_len;
    int   pick;
    int   y;
    int   m;
    int   d;
    cmd_t dir;
    cmd_t back;
    sent = 0;
    while (sent < total) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        y = $urandom_range(0, 16383);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
      end else if (pick == 2) begin
        // sit next to the year wrap
        if ($urandom_range(0, 1)) begin
          y = int'(YEAR_MAX);
          m = int'(MONTHS_PER_YEAR);
          d = 31 - $urandom_range(0, 2);
        end else begin
          y = 0;
          m = 1;
          d = $urandom_range(1, 3);
        end
      end else begin
        y = $urandom_range(0, int'(YEAR_MAX));
        m = $urandom_range(1, 12);
        d = $urandom_range(0, 1) ? days_in_month(y, m) - $urandom_range(0, 2)
                                 : $urandom_range(1, 3);
      end
      send_request(CMD_LOAD, y, m, d);
      sent++;
      run_len = $urandom_range(3, 40);
      dir  = $urandom_range(0, 1) ? CMD_NEXT : CMD_PREV;
      back = (dir == CMD_NEXT) ? CMD_PREV : CMD_NEXT;
      repeat (run_len) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) send_step(CMD_READ);
        else if (pick == 1) send_step(back);
        else send_step(dir);
        sent++;
      end
    end
  endtask

  // Hold off results for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    send_idle_on = 1'b0;
    send_request(CMD_LOAD, 1999, 12, 20);
    hold_left = 80;
    repeat (40) send_step(CMD_NEXT);
    send_idle_on = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    tracked_date.year  = 14'd0;
    tracked_date.month = 4'd1;
    tracked_date.day   = 5'd1;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_load_limits();
    test_leap_rule();
    test_month_ends();
    test_random_walks(450);
    test_output_backpressure();
    // Run the last part with no idling on either side
    send_idle_on  = 1'b0;
    stall_idle_on = 1'b0;
    test_random_walks(150);
    req_valid <= 1'b0;

    // Drain the pipeline and allow for stray results
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_dates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_dates.size()));

    $display("Covered %0d loads, %0d next-day, %0d previous-day and %0d read requests,",
             cmd_count[CMD_LOAD], cmd_count[CMD_NEXT], cmd_count[CMD_PREV],
             cmd_count[CMD_READ]);
    $display("with %0d results checked and %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/cdc_pkg.sv
sv/cdc_update.sv
sv/cdc_digits.sv
sv/calendar_date_up_down_counter.sv
sv/cdc_checker.sv
tb/sv/calendar_date_up_down_counter_test.sv
